>>> design/pkfe_pkg.sv
// package: constants, types and helper functions of the particle keyframe evaluator
`timescale 1ns / 1ps
`default_nettype none
package pkfe_pkg;

   localparam int NUM_KEYS  = 4;
   localparam int KEY_W     = $clog2(NUM_KEYS);
   localparam int AGE_W     = 24;
   localparam int FRAC_W    = 16;
   localparam int DIV_STEPS = 16;
   localparam int REM_W     = AGE_W + 1;
   localparam int CSR_IDX_W = 3;

   localparam logic [FRAC_W-1:0] ONE_Q15 = 16'h8000;
   localparam logic [15:0]       RECIP_255 = 16'd32897;

   localparam logic [63:0] KEY_TIMES_RST  = 64'h8000_547B_2A3D_0000;
   localparam logic [63:0] KEY_SIZES_RST  = 64'h0100_0100_0100_0100;
   localparam logic [63:0] KEY_COLORS_RST = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] AMBIENT_RST    = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      CSR_KEY_TIMES       = 3'd0,
      CSR_KEY_SIZES       = 3'd1,
      CSR_KEY_COLORS_LOW  = 3'd2,
      CSR_KEY_COLORS_HIGH = 3'd3,
      CSR_AMBIENT_COLOR   = 3'd4,
      CSR_AMBIENT_FACTOR  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_LIFE = 2'd1,
      STATUS_CLAMPED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FRAC_UPPER = 2'd0,
      FRAC_ZERO  = 2'd1,
      FRAC_DIV   = 2'd2
   } frac_mode_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                               input logic [AGE_W-1:0] den);
      logic [REM_W-1:0] d;
      d = {1'b0, den};
      if (rem >= d) begin
         div_step = {1'b1, rem - d};
      end else begin
         div_step = {1'b0, rem};
      end
   endfunction

endpackage
`default_nettype wire

>>> design/particle_keyframe_size_color_eval.sv
// top level: pipelined keyframe size and color evaluator with ambient blend
// one item per cycle sustained while the output is not stalled
// two 16-stage restoring dividers (life fraction, segment fraction) set the depth
// the whole pipeline holds while a result waits and rsp_tready is low
// reset empties the pipeline and loads the default key tables and ambient settings
`timescale 1ns / 1ps
`default_nettype none
module particle_keyframe_size_color_eval (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // current_age[23:0], total_lifetime[47:24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // size[15:0], red, green, blue, alpha
   output logic [1:0]       rsp_tuser,   // status[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [pkfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0] csr_data
);
   import pkfe_pkg::*;

   logic [63:0] key_times_ff, key_sizes_ff, colors_lo_ff, colors_hi_ff;
   logic [31:0] ambient_ff;
   logic [8:0]  factor_ff;
   logic [8:0]  k_w;
   logic        adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_times_ff <= KEY_TIMES_RST;
         key_sizes_ff <= KEY_SIZES_RST;
         colors_lo_ff <= KEY_COLORS_RST;
         colors_hi_ff <= KEY_COLORS_RST;
         ambient_ff   <= AMBIENT_RST;
         factor_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_TIMES:       key_times_ff <= csr_data;
            CSR_KEY_SIZES:       key_sizes_ff <= csr_data;
            CSR_KEY_COLORS_LOW:  colors_lo_ff <= csr_data;
            CSR_KEY_COLORS_HIGH: colors_hi_ff <= csr_data;
            CSR_AMBIENT_COLOR:   ambient_ff   <= csr_data[31:0];
            CSR_AMBIENT_FACTOR:  factor_ff    <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign k_w = factor_ff[8] ? 9'd256 : factor_ff;

   // life fraction divider
   logic [REM_W-1:0]  a_rem_ff [0:DIV_STEPS];
   logic [FRAC_W-1:0] a_q_ff   [0:DIV_STEPS];
   logic [AGE_W-1:0]  a_den_ff [0:DIV_STEPS];
   logic [1:0]        a_st_ff  [0:DIV_STEPS];
   logic              a_v_ff   [0:DIV_STEPS];

   logic [AGE_W-1:0] age_w, life_w;
   logic [1:0]       st_in;

   assign age_w  = req_tdata[23:0];
   assign life_w = req_tdata[47:24];

   always_comb begin
      if (life_w == '0) begin
         st_in = STATUS_ZERO_LIFE;
      end else if (age_w > life_w) begin
         st_in = STATUS_CLAMPED;
      end else begin
         st_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      logic [REM_W:0]   r;
      logic [REM_W-1:0] sh;
      if (adv) begin
         a_rem_ff[0] <= (st_in == STATUS_OK) ? {1'b0, age_w} : '0;
         a_den_ff[0] <= (st_in == STATUS_OK) ? life_w : {{(AGE_W-1){1'b0}}, 1'b1};
         a_q_ff[0]   <= '0;
         a_st_ff[0]  <= st_in;
         for (int j = 0; j < DIV_STEPS; j++) begin
            sh = (j == 0) ? a_rem_ff[j] : {a_rem_ff[j][REM_W-2:0], 1'b0};
            r  = div_step(sh, a_den_ff[j]);
            a_rem_ff[j+1] <= r[REM_W-1:0];
            a_q_ff[j+1]   <= {a_q_ff[j][FRAC_W-2:0], r[REM_W]};
            a_den_ff[j+1] <= a_den_ff[j];
            a_st_ff[j+1]  <= a_st_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STEPS; j++) a_v_ff[j] <= 1'b0;
      end else if (adv) begin
         a_v_ff[0] <= req_tvalid;
         for (int j = 0; j < DIV_STEPS; j++) a_v_ff[j+1] <= a_v_ff[j];
      end
   end

   assign req_tready = adv;

   // segment search
   logic [FRAC_W-1:0] t_w, lo_t_w, hi_t_w;
   logic [KEY_W-1:0]  lo_k_w, hi_k_w;
   frac_mode_type     mode_w;

   always_comb begin
      t_w = (a_st_ff[DIV_STEPS] != STATUS_OK) ? ONE_Q15 : a_q_ff[DIV_STEPS];
      lo_k_w = KEY_W'(NUM_KEYS - 1);
      hi_k_w = KEY_W'(NUM_KEYS - 1);
      mode_w = FRAC_UPPER;
      for (int i = NUM_KEYS - 1; i >= 1; i--) begin
         if (key_times_ff[16*i +: 16] >= t_w) begin
            lo_k_w = KEY_W'(i - 1);
            hi_k_w = KEY_W'(i);
            mode_w = FRAC_DIV;
         end
      end
      lo_t_w = key_times_ff[16*lo_k_w +: 16];
      hi_t_w = key_times_ff[16*hi_k_w +: 16];
      if (mode_w == FRAC_DIV) begin
         if (hi_t_w <= lo_t_w) begin
            mode_w = FRAC_UPPER;
         end else if (t_w <= lo_t_w) begin
            mode_w = FRAC_ZERO;
         end
      end
   end

   // segment fraction divider
   logic [REM_W-1:0]  b_rem_ff  [0:DIV_STEPS];
   logic [FRAC_W-1:0] b_q_ff    [0:DIV_STEPS];
   logic [AGE_W-1:0]  b_den_ff  [0:DIV_STEPS];
   logic [1:0]        b_st_ff   [0:DIV_STEPS];
   logic [KEY_W-1:0]  b_lo_ff   [0:DIV_STEPS];
   logic [KEY_W-1:0]  b_hi_ff   [0:DIV_STEPS];
   frac_mode_type     b_mode_ff [0:DIV_STEPS];
   logic              b_v_ff    [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      logic [REM_W:0]   r;
      logic [REM_W-1:0] sh;
      if (adv) begin
         if (mode_w == FRAC_DIV) begin
            b_rem_ff[0] <= REM_W'(t_w - lo_t_w);
            b_den_ff[0] <= AGE_W'(hi_t_w - lo_t_w);
         end else begin
            b_rem_ff[0] <= '0;
            b_den_ff[0] <= {{(AGE_W-1){1'b0}}, 1'b1};
         end
         b_q_ff[0]    <= '0;
         b_st_ff[0]   <= a_st_ff[DIV_STEPS];
         b_lo_ff[0]   <= lo_k_w;
         b_hi_ff[0]   <= hi_k_w;
         b_mode_ff[0] <= mode_w;
         for (int j = 0; j < DIV_STEPS; j++) begin
            sh = (j == 0) ? b_rem_ff[j] : {b_rem_ff[j][REM_W-2:0], 1'b0};
            r  = div_step(sh, b_den_ff[j]);
            b_rem_ff[j+1]  <= r[REM_W-1:0];
            b_q_ff[j+1]    <= {b_q_ff[j][FRAC_W-2:0], r[REM_W]};
            b_den_ff[j+1]  <= b_den_ff[j];
            b_st_ff[j+1]   <= b_st_ff[j];
            b_lo_ff[j+1]   <= b_lo_ff[j];
            b_hi_ff[j+1]   <= b_hi_ff[j];
            b_mode_ff[j+1] <= b_mode_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STEPS; j++) b_v_ff[j] <= 1'b0;
      end else if (adv) begin
         b_v_ff[0] <= a_v_ff[DIV_STEPS];
         for (int j = 0; j < DIV_STEPS; j++) b_v_ff[j+1] <= b_v_ff[j];
      end
   end

   // fraction and key fetch
   logic [FRAC_W-1:0] f_ff;
   logic [15:0]       f_sa_ff, f_sb_ff;
   logic [31:0]       f_ca_ff, f_cb_ff;
   logic [1:0]        f_st_ff;
   logic              f_v_ff;
   logic [FRAC_W-1:0] f_in;
   logic [63:0]       key_colors_w [0:1];
   logic [KEY_W-1:0]  lo_k, hi_k;

   assign key_colors_w[0] = colors_lo_ff;
   assign key_colors_w[1] = colors_hi_ff;
   assign lo_k = b_lo_ff[DIV_STEPS];
   assign hi_k = b_hi_ff[DIV_STEPS];

   always_comb begin
      case (b_mode_ff[DIV_STEPS])
         FRAC_ZERO: f_in = '0;
         FRAC_DIV:  f_in = b_q_ff[DIV_STEPS];
         default:   f_in = ONE_Q15;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff    <= f_in;
         f_sa_ff <= key_sizes_ff[16*lo_k +: 16];
         f_sb_ff <= key_sizes_ff[16*hi_k +: 16];
         f_ca_ff <= key_colors_w[lo_k[1]][32*lo_k[0] +: 32];
         f_cb_ff <= key_colors_w[hi_k[1]][32*hi_k[0] +: 32];
         f_st_ff <= b_st_ff[DIV_STEPS];
      end
   end

   // interpolation
   logic [15:0] l_size_ff;
   logic [7:0]  l_c_ff [0:3];
   logic [1:0]  l_st_ff;
   logic        l_v_ff;
   logic [16:0] g_w;
   logic [32:0] s_w;
   logic [24:0] cs_w [0:3];

   assign g_w = 17'h1_0000 - {1'b0, f_ff} - 17'h0_8000;

   always_comb begin
      s_w = 33'(f_sa_ff) * 33'(g_w[15:0]) + 33'(f_sb_ff) * 33'(f_ff) + 33'd16384;
      for (int ch = 0; ch < 4; ch++) begin
         cs_w[ch] = 25'(f_ca_ff[8*ch +: 8]) * 25'(g_w[15:0])
                    + 25'(f_cb_ff[8*ch +: 8]) * 25'(f_ff) + 25'd16384;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_size_ff <= s_w[30:15];
         for (int ch = 0; ch < 4; ch++) l_c_ff[ch] <= cs_w[ch][22:15];
         l_st_ff <= f_st_ff;
      end
   end

   // ambient product
   logic [15:0] p_ff [0:3];
   logic [7:0]  p_c_ff [0:3];
   logic [15:0] p_size_ff;
   logic [1:0]  p_st_ff;
   logic        p_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < 4; ch++) begin
            p_ff[ch]   <= 16'(l_c_ff[ch]) * 16'(ambient_ff[8*ch +: 8]) + 16'd127;
            p_c_ff[ch] <= l_c_ff[ch];
         end
         p_size_ff <= l_size_ff;
         p_st_ff   <= l_st_ff;
      end
   end

   // divide by 255 through reciprocal
   logic [7:0]  q_m_ff [0:3];
   logic [7:0]  q_c_ff [0:3];
   logic [15:0] q_size_ff;
   logic [1:0]  q_st_ff;
   logic        q_v_ff;
   logic [31:0] mq_w [0:3];

   always_comb begin
      for (int ch = 0; ch < 4; ch++) mq_w[ch] = 32'(p_ff[ch]) * 32'(RECIP_255);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < 4; ch++) begin
            q_m_ff[ch] <= mq_w[ch][30:23];
            q_c_ff[ch] <= p_c_ff[ch];
         end
         q_size_ff <= p_size_ff;
         q_st_ff   <= p_st_ff;
      end
   end

   // blend and output register
   logic [47:0] o_data_ff;
   logic [1:0]  o_st_ff;
   logic        o_v_ff;
   logic [17:0] bl_w [0:3];
   logic [8:0]  kc_w;

   assign kc_w = 9'd256 - k_w;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         bl_w[ch] = 18'(q_c_ff[ch]) * 18'(kc_w) + 18'(q_m_ff[ch]) * 18'(k_w) + 18'd128;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_data_ff <= {bl_w[3][15:8], bl_w[2][15:8], bl_w[1][15:8], bl_w[0][15:8],
                       q_size_ff};
         o_st_ff   <= q_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         l_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         q_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= b_v_ff[DIV_STEPS];
         l_v_ff <= f_v_ff;
         p_v_ff <= l_v_ff;
         q_v_ff <= p_v_ff;
         o_v_ff <= q_v_ff;
      end
   end

   assign adv        = !o_v_ff || rsp_tready;
   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_st_ff;

`ifndef NO_ASSERTIONS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("undefined status code on result");

   a_life_frac: assert property (@(posedge clock) disable iff (reset)
      (a_v_ff[DIV_STEPS] && a_st_ff[DIV_STEPS] == STATUS_OK)
      |-> (a_q_ff[DIV_STEPS] <= ONE_Q15))
      else $error("life fraction above one");

   a_seg_frac: assert property (@(posedge clock) disable iff (reset)
      f_v_ff |-> (f_ff <= ONE_Q15))
      else $error("segment fraction above one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (f_v_ff && !adv) |=> (f_v_ff && $stable(f_ff)))
      else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

>>> verif/particle_keyframe_size_color_eval_tb.sv
// testbench: keyframe size and color evaluator checked against a behavioral predictor
`timescale 1ns / 1ps
`default_nettype none
module particle_keyframe_size_color_eval_tb;
   import pkfe_pkg::*;

   // field order matches {rsp_tdata, rsp_tuser}, highest bits first
   typedef struct packed {
      logic [7:0]  alpha;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [15:0] size;
      logic [1:0]  status;
   } particle_look_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] times_reg, sizes_reg, colors_lo_reg, colors_hi_reg;
   logic [31:0] amb_color_reg;
   logic [8:0]  amb_factor_reg;

   particle_look_type looks_pending[$];
   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;
   bit stall_mode = 1'b0;

   localparam int LATENCY = 39;
   localparam int CYCLE_LIMIT = 400000;

   particle_keyframe_size_color_eval u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] blend_lerp(logic [31:0] a, logic [31:0] b,
                                              logic [31:0] f);
      logic [63:0] s;
      s = 64'(a) * (32768 - f) + 64'(b) * f + 16384;
      return 32'(s >> 15);
   endfunction

   function automatic particle_look_type predict_look(logic [23:0] age, logic [23:0] life);
      particle_look_type r;
      logic [31:0] t, f, lo, hi, k, c0, c1, a, b, amb, c, m;
      logic [47:0] num;
      int lo_k, hi_k;
      bit found;
      f = 32768;
      lo_k = NUM_KEYS - 1;
      hi_k = NUM_KEYS - 1;
      found = 1'b0;
      r.status = STATUS_OK;
      if (life == 0) begin
         r.status = STATUS_ZERO_LIFE;
         t = 32768;
      end else if (age > life) begin
         r.status = STATUS_CLAMPED;
         t = 32768;
      end else begin
         num = 48'(age) << 15;
         t = 32'(num / life);
      end
      for (int i = 1; i < NUM_KEYS; i++) begin
         if (!found && 32'(times_reg[i*16 +: 16]) >= t) begin
            found = 1'b1;
            lo = 32'(times_reg[(i-1)*16 +: 16]);
            hi = 32'(times_reg[i*16 +: 16]);
            lo_k = i - 1;
            hi_k = i;
            if (hi <= lo) f = 32768;
            else if (t <= lo) f = 0;
            else f = 32'((64'(t - lo) << 15) / (hi - lo));
         end
      end
      r.size = 16'(blend_lerp(32'(sizes_reg[lo_k*16 +: 16]),
                              32'(sizes_reg[hi_k*16 +: 16]), f));
      k = (amb_factor_reg > 256) ? 256 : 32'(amb_factor_reg);
      c0 = (lo_k >= 2) ? colors_hi_reg[(lo_k % 2)*32 +: 32]
                       : colors_lo_reg[(lo_k % 2)*32 +: 32];
      c1 = (hi_k >= 2) ? colors_hi_reg[(hi_k % 2)*32 +: 32]
                       : colors_lo_reg[(hi_k % 2)*32 +: 32];
      for (int ch = 0; ch < 4; ch++) begin
         a = 32'(c0[ch*8 +: 8]);
         b = 32'(c1[ch*8 +: 8]);
         amb = 32'(amb_color_reg[ch*8 +: 8]);
         c = blend_lerp(a, b, f);
         m = (c * amb + 127) / 255;
         c = (c * (256 - k) + m * k + 128) >> 8;
         case (ch)
            0: r.red = c[7:0];
            1: r.green = c[7:0];
            2: r.blue = c[7:0];
            default: r.alpha = c[7:0];
         endcase
      end
      return r;
   endfunction

   // receiver stall pattern and result checking
   always @(posedge clock) begin
      particle_look_type got, want;
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser};
         if (looks_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", got);
         end else begin
            want = looks_pending.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected size %h rgba %h %h %h %h st %0d, ",
                            "got size %h rgba %h %h %h %h st %0d"},
                     want.size, want.red, want.green, want.blue, want.alpha, want.status,
                     got.size, got.red, got.green, got.blue, got.alpha, got.status);
            end
         end
      end
      if (cycles % 300 == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KEY_TIMES: times_reg = value;
         CSR_KEY_SIZES: sizes_reg = value;
         CSR_KEY_COLORS_LOW: colors_lo_reg = value;
         CSR_KEY_COLORS_HIGH: colors_hi_reg = value;
         CSR_AMBIENT_COLOR: amb_color_reg = value[31:0];
         CSR_AMBIENT_FACTOR: amb_factor_reg = value[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_particle(logic [23:0] age, logic [23:0] life);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {life, age};
      do @(posedge clock); while (!req_tready);
      looks_pending.push_back(predict_look(age, life));
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (looks_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic random_particle();
      logic [23:0] life, age;
      case ($urandom_range(0, 9))
         0: life = '0;
         1: life = 24'($urandom_range(1, 16));
         default: life = 24'($urandom());
      endcase
      case ($urandom_range(0, 7))
         0: age = 24'($urandom());
         1: age = 24'(life + $urandom_range(1, 5));
         2: age = life;
         3: age = '0;
         default: age = (life == 0) ? 24'($urandom()) : 24'($urandom() % (32'(life) + 1));
      endcase
      send_particle(age, life);
   endtask

   task automatic test_defaults();
      send_particle(24'd0, 24'd1000);
      send_particle(24'd1000, 24'd1000);
      send_particle(24'd500, 24'd1000);
      send_particle(24'd5, 24'd0);
      send_particle(24'hFFFFFF, 24'd1);
      send_particle(24'hFFFFFE, 24'hFFFFFF);
      send_particle(24'hFFFFFF, 24'hFFFFFF);
      send_particle(24'd1, 24'hFFFFFF);
      send_particle(24'h555555, 24'hAAAAAA);
      send_particle(24'hAAAAAA, 24'hFFFFFF);
      drain_block();
   endtask

   task automatic test_degenerate_keys();
      // repeated and inverted times, no key at or above t
      write_csr(CSR_KEY_TIMES, 64'h4000_4000_6000_1000);
      write_csr(CSR_KEY_SIZES, 64'hFFFF_0000_1234_FFFF);
      write_csr(CSR_KEY_COLORS_LOW, 64'h00FF_00FF_FF00_FF00);
      write_csr(CSR_KEY_COLORS_HIGH, 64'h0000_0000_FFFF_FFFF);
      write_csr(CSR_AMBIENT_COLOR, 64'hFFFF_FFFF_0000_0000);
      write_csr(CSR_AMBIENT_FACTOR, 64'h1FF);
      send_particle(24'd0, 24'd100);
      send_particle(24'd10, 24'd100);
      send_particle(24'd50, 24'd100);
      send_particle(24'd99, 24'd100);
      send_particle(24'd100, 24'd100);
      send_particle(24'd7, 24'd0);
      send_particle(24'd200, 24'd100);
      drain_block();
      write_csr(CSR_KEY_TIMES, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_AMBIENT_FACTOR, 64'd256);
      send_particle(24'd30, 24'd100);
      send_particle(24'd9, 24'd0);
      drain_block();
      write_csr(CSR_KEY_TIMES, 64'h0);
      write_csr(CSR_AMBIENT_FACTOR, 64'd0);
      send_particle(24'd0, 24'd100);
      send_particle(24'd40, 24'd100);
      drain_block();
   endtask

   task automatic test_random_settings();
      logic [15:0] tk[4];
      for (int ph = 0; ph < 7; ph++) begin
         for (int i = 0; i < 4; i++) tk[i] = 16'($urandom_range(0, 32768));
         if (ph % 2 == 0) tk.sort();
         write_csr(CSR_KEY_TIMES, {tk[3], tk[2], tk[1], tk[0]});
         write_csr(CSR_KEY_SIZES, {$urandom(), $urandom()});
         write_csr(CSR_KEY_COLORS_LOW, {$urandom(), $urandom()});
         write_csr(CSR_KEY_COLORS_HIGH, {$urandom(), $urandom()});
         write_csr(CSR_AMBIENT_COLOR, {$urandom(), $urandom()});
         write_csr(CSR_AMBIENT_FACTOR, (ph == 1) ? 64'h1FF : 64'($urandom_range(0, 300)));
         repeat (100) random_particle();
         drain_block();
      end
   endtask

   initial begin
      times_reg = KEY_TIMES_RST;
      sizes_reg = KEY_SIZES_RST;
      colors_lo_reg = KEY_COLORS_RST;
      colors_hi_reg = KEY_COLORS_RST;
      amb_color_reg = AMBIENT_RST;
      amb_factor_reg = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_degenerate_keys();
      test_random_settings();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
